// ===== rtl/set_assoc_cache_timing_model_unit_assert.svh =====
// ----------------------------------------------------------------------------
// set_assoc_cache_timing_model_unit_assert
// Assertion macros for the cache timing model.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TIMING_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TIMING_MODEL_UNIT_ASSERT_SVH
// holds: condition must hold every cycle outside reset
`define SACT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// implies: antecedent implies consequent in the next cycle
`define SACT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg
// Types and constants shared by the cache timing model.
// ----------------------------------------------------------------------------
package sact_pkg;
    localparam int MAX_SETS_DEF  = 256;
    localparam int MAX_WAYS_DEF  = 8;
    localparam int ADDR_BITS_DEF = 32;
    localparam int TOTAL_W       = 48;
    localparam int COST_W        = 16;

    localparam logic [2:0] REG_SETS_LOG2   = 3'd0;
    localparam logic [2:0] REG_WAYS        = 3'd1;
    localparam logic [2:0] REG_BLOCK_LOG2  = 3'd2;
    localparam logic [2:0] REG_WRITE_ALLOC = 3'd3;
    localparam logic [2:0] REG_WRITE_THRU  = 3'd4;
    localparam logic [2:0] REG_REPL_LRU    = 3'd5;

    localparam logic [COST_W-1:0] COST_HIT      = 16'd1;
    localparam logic [COST_W-1:0] COST_WT_STORE = 16'd101;
    localparam logic [COST_W-1:0] COST_NO_ALLOC = 16'd100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_OUT
    } t_state;
endpackage

// ===== rtl/sact_set_ram.sv =====
// ----------------------------------------------------------------------------
// sact_set_ram
// One row per set: tag, dirty and rank of every way; registered read.
// ----------------------------------------------------------------------------
module sact_set_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/set_assoc_cache_timing_model_unit.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_timing_model_unit
// Set-associative cache tag and timing model with LRU or FIFO replacement.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// s_axis   in   tvalid/tready       tuser=kind, tdata=address
// m_axis   out  tvalid/tready       tuser=hit,dirty_writeback, tdata=cycles,total
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
// An access passes the set row read, then compare and write-back of the
// row, then the result register.
// Synchronous active-low reset clears the set valid bits and the cycle total.
// A stalled result holds the block; the next access is taken once it leaves.
// A pending configuration write holds off the input for that cycle.
module set_assoc_cache_timing_model_unit
    import sact_pkg::*;
#(
    parameter int MAX_SETS  = MAX_SETS_DEF,
    parameter int MAX_WAYS  = MAX_WAYS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] access_cycles, [63:16] running total
    output logic [1:0]  m_axis_tuser,   // [0] hit, [1] dirty_writeback
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    `include "set_assoc_cache_timing_model_unit_assert.svh"

    localparam int SL_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MSL   = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FIL_W = $clog2(MAX_WAYS + 1);
    localparam int TAG_W = ADDR_BITS - 2;
    localparam int ENT_W = TAG_W + 1 + WAY_W;
    localparam int FIL_LO = ENT_W * MAX_WAYS;
    localparam int ROW_W = FIL_LO + FIL_W;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    logic [3:0] r_sets_log2, r_ways, r_blk_log2;
    logic       r_wr_alloc, r_wr_thru, r_lru;
    t_state     r_state, n_state;

    logic             r_store;
    logic [ADDR_BITS-1:0] r_addr;
    logic [SL_W-1:0]  r_set;
    logic [MAX_SETS-1:0] r_vld;
    logic             r_hit, r_wb;
    logic [COST_W-1:0]  r_cost;
    logic [TOTAL_W-1:0] r_total;

    assign o_cfg_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sets_log2 <= 4'd8;
            r_ways      <= 4'd4;
            r_blk_log2  <= 4'd4;
            r_wr_alloc  <= 1'b1;
            r_wr_thru   <= 1'b0;
            r_lru       <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SETS_LOG2:   r_sets_log2 <= i_cfg_data;
                REG_WAYS:        r_ways      <= i_cfg_data;
                REG_BLOCK_LOG2:  r_blk_log2  <= i_cfg_data;
                REG_WRITE_ALLOC: r_wr_alloc  <= i_cfg_data[0];
                REG_WRITE_THRU:  r_wr_thru   <= i_cfg_data[0];
                REG_REPL_LRU:    r_lru       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // geometry clamps
    logic [3:0] sl_c, bl_c;
    logic [FIL_W-1:0] ways_c;
    always_comb begin
        sl_c = (r_sets_log2 > 4'(MSL)) ? 4'(MSL) : r_sets_log2;
        bl_c = (r_blk_log2 < 4'd2) ? 4'd2 : ((r_blk_log2 > 4'd10) ? 4'd10 : r_blk_log2);
        if (r_ways == 4'd0) begin
            ways_c = FIL_W'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways_c = FIL_W'(MAX_WAYS);
        end else begin
            ways_c = FIL_W'(r_ways);
        end
    end

    logic [ADDR_BITS-1:0] in_addr;
    logic [SL_W-1:0]      in_set;
    logic [ADDR_BITS-1:0] in_shift;
    logic [ADDR_BITS-1:0] set_mask;
    assign in_addr  = ADDR_BITS'(s_axis_tdata);
    assign in_shift = in_addr >> bl_c;
    assign set_mask = (ADDR_BITS'(1) << sl_c) - ADDR_BITS'(1);
    assign in_set   = SL_W'(in_shift & set_mask);

    logic accept;
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign accept = s_axis_tvalid && s_axis_tready;

    // set row memory: ways then fill count
    logic             ram_we;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;
    sact_set_ram #(.DEPTH(1 << SL_W), .WIDTH(ROW_W)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_set),
        .i_wdata(ram_wdata),
        .i_raddr(in_set),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_store <= s_axis_tuser;
            r_addr  <= in_addr;
            r_set   <= in_set;
        end
    end

    // lookup and update
    logic [TAG_W-1:0] tags  [MAX_WAYS];
    logic             dirt  [MAX_WAYS];
    logic [WAY_W-1:0] rank  [MAX_WAYS];
    logic [TAG_W-1:0] c_tag;
    logic [4:0]       tag_sh;
    logic [FIL_W-1:0] fill, n_fill;
    logic             c_hit, c_wb, alloc;
    logic [WAY_W-1:0] way, old_rank;
    logic [COST_W-1:0] fcost, cost;
    logic [TOTAL_W:0]  sum;

    always_comb begin
        tag_sh = 5'(bl_c) + 5'(sl_c);
        c_tag = TAG_W'(r_addr >> tag_sh);
        fill  = r_vld[r_set] ? ram_rdata[FIL_LO +: FIL_W] : '0;
        if (32'(fill) > MAX_WAYS) fill = FIL_W'(MAX_WAYS);
        for (int i = 0; i < MAX_WAYS; i++) begin
            tags[i] = ram_rdata[i*ENT_W +: TAG_W];
            dirt[i] = ram_rdata[i*ENT_W + TAG_W];
            rank[i] = ram_rdata[i*ENT_W + TAG_W + 1 +: WAY_W];
        end
        c_hit = 1'b0;
        way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (FIL_W'(i) < fill && tags[i] == c_tag) begin
                c_hit = 1'b1;
                way   = WAY_W'(i);
            end
        end
        fcost  = COST_W'(25) << bl_c;
        cost   = '0;
        c_wb   = 1'b0;
        n_fill = fill;
        alloc  = !r_store || r_wr_alloc;
        ram_we = 1'b0;
        if (r_state == ST_LOOK) begin
            ram_we = 1'b1;
        end
        old_rank = '0;
        if (c_hit) begin
            cost = (r_store && r_wr_thru) ? COST_WT_STORE : COST_HIT;
            if (r_store && !r_wr_thru) dirt[way] = 1'b1;
            if (r_lru) begin
                old_rank = rank[way];
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (FIL_W'(i) < fill && rank[i] > old_rank) rank[i] = rank[i] - 1'b1;
                end
                rank[way] = WAY_W'(fill - 1'b1);
            end
        end else if (!alloc) begin
            cost   = COST_NO_ALLOC;
            ram_we = 1'b0;
        end else begin
            if (fill < ways_c) begin
                way       = WAY_W'(fill);
                n_fill    = fill + 1'b1;
                rank[way] = WAY_W'(fill);
            end else begin
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (FIL_W'(i) < fill && rank[i] == '0) way = WAY_W'(i);
                end
                if (dirt[way]) begin
                    c_wb = 1'b1;
                    cost = fcost;
                end
                old_rank = rank[way];
                for (int i = 0; i < MAX_WAYS; i++) begin
                    if (FIL_W'(i) < fill && rank[i] > old_rank) rank[i] = rank[i] - 1'b1;
                end
                rank[way] = WAY_W'(fill - 1'b1);
            end
            tags[way] = c_tag;
            cost = cost + fcost + ((r_store && r_wr_thru) ? COST_WT_STORE : COST_HIT);
            dirt[way] = r_store && !r_wr_thru;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            ram_wdata[i*ENT_W +: ENT_W] = {rank[i], dirt[i], tags[i]};
        end
        ram_wdata[FIL_LO +: FIL_W] = n_fill;
        sum = {1'b0, r_total} + (TOTAL_W + 1)'(cost);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_total <= '0;
        end else if (r_state == ST_LOOK) begin
            if (ram_we) r_vld[r_set] <= 1'b1;
            r_total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_hit  <= c_hit;
            r_wb   <= c_wb;
            r_cost <= cost;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_LOOK;
            ST_LOOK: n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {r_total, r_cost};
    assign m_axis_tuser  = {r_wb, r_hit};

    `SACT_HOLDS(a_wb_miss, i_clk, i_rst_n, !(m_axis_tvalid && r_hit && r_wb),
        "writeback reported on a hit")
    `SACT_NEXT(a_look_out, i_clk, i_rst_n, r_state == ST_LOOK, m_axis_tvalid,
        "result not presented after lookup")
    `SACT_NEXT(a_total_mono, i_clk, i_rst_n, r_state == ST_LOOK,
        r_total >= $past(r_total), "cycle total decreased")
endmodule
